// ===== design/ecal_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ecal_pkg;

  localparam int unsigned EPOCH_W  = 32;
  localparam int unsigned OFFSET_W = 18;
  localparam int unsigned SUM_W    = 33;
  localparam int unsigned V_W      = 26;
  localparam int unsigned DAYS_W   = 16;
  localparam int unsigned Z_W      = 20;
  localparam int unsigned TOD_W    = 17;
  localparam int unsigned DOE_W    = 18;
  localparam int unsigned YOE_W    = 9;
  localparam int unsigned DOY_W    = 9;
  localparam int unsigned ERA_W    = 3;
  localparam int unsigned YEAR_W   = 12;

  // bias is a whole number of days that lifts every possible sum above zero
  localparam logic [SUM_W:0]   DAY_BIAS = 34'd2147731200;
  // day index relative to 0000-03-01, with the bias days taken back out
  localparam logic [Z_W-1:0]   Z_BASE   = 20'd694610;
  localparam logic [Z_W-1:0]   ERA_DAYS = 20'd146097;
  localparam logic [DOE_W-1:0] LAST_DOE = 18'd146096;

  // ceil(2^s / d) reciprocals, s picked so the quotient is exact over the input range
  localparam logic [26:0] RECIP_675   = 27'(((64'd1 << 36) + 64'd674) / 64'd675);
  localparam logic [18:0] RECIP_1460  = 19'(((64'd1 << 29) + 64'd1459) / 64'd1460);
  localparam logic [18:0] RECIP_36524 = 19'(((64'd1 << 34) + 64'd36523) / 64'd36524);
  localparam logic [18:0] RECIP_365   = 19'(((64'd1 << 27) + 64'd364) / 64'd365);
  localparam logic [9:0]  RECIP_100   = 10'(((64'd1 << 16) + 64'd99) / 64'd100);
  localparam logic [11:0] RECIP_153   = 12'(((64'd1 << 19) + 64'd152) / 64'd153);
  localparam logic [11:0] RECIP_5     = 12'(((64'd1 << 14) + 64'd4) / 64'd5);
  localparam logic [20:0] RECIP_7     = 21'(((64'd1 << 23) + 64'd6) / 64'd7);
  localparam logic [17:0] RECIP_3600  = 18'(((64'd1 << 29) + 64'd3599) / 64'd3600);
  localparam logic [12:0] RECIP_60    = 13'(((64'd1 << 18) + 64'd59) / 64'd60);

  localparam int unsigned SPLIT_STAGES = 3;
  localparam int unsigned DATE_STAGES  = 8;
  localparam int unsigned TOD_PAD      = DATE_STAGES - 3;
  localparam int unsigned LATENCY      = SPLIT_STAGES + DATE_STAGES;

  typedef struct packed {
    logic [Z_W-1:0]   z;
    logic [TOD_W-1:0] tod;
  } ecal_day_t;

  typedef struct packed {
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
  } ecal_tod_t;

  typedef struct packed {
    logic [4:0] day_of_month;
    logic [3:0] month_index;
    logic [7:0] years_since_1900;
    logic [2:0] weekday;
    logic [8:0] day_of_year;
  } ecal_date_t;

  function automatic logic [DOY_W-1:0] days_before_month(input logic [3:0] mon);
    logic [DOY_W-1:0] d;
    case (mon)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

// ===== design/epoch_seconds_to_calendar_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Converts a signed 32-bit seconds-since-1970 count, plus the zone offset written
// through cfg_we / zone_offset_seconds, into broken-down Gregorian time. A word is
// taken on any cycle with start high; busy never rises, so one conversion can
// enter every clock. Each result appears on done for a single cycle. On its way,
// three stages split seconds into days and time of day,
// then eight stages walk the day count through era, year, month and day, with the
// divisions done as constant-reciprocal multiplies spread across the stages. The
// receiver cannot stall; results must be captured on the done cycle. Write the
// offset only while no conversion is in flight.
module epoch_seconds_to_calendar_core import ecal_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [EPOCH_W-1:0]  epoch_seconds,
  input  wire logic                cfg_we,
  input  wire logic [OFFSET_W-1:0] zone_offset_seconds,
  output logic                     done,
  output logic [5:0]               second,
  output logic [5:0]               minute,
  output logic [4:0]               hour,
  output logic [4:0]               day_of_month,
  output logic [3:0]               month_index,
  output logic [7:0]               years_since_1900,
  output logic [2:0]               weekday,
  output logic [8:0]               day_of_year
);

  logic [OFFSET_W-1:0] zone_offset;
  logic                day_valid, tod_valid, date_valid;
  ecal_day_t           day;
  ecal_tod_t           tod_res;
  ecal_date_t          date_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      zone_offset <= '0;
    end else if (cfg_we) begin
      zone_offset <= zone_offset_seconds;
    end
  end

  assign busy = 1'b0;

  ecal_split u_split (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (start && !busy),
    .epoch_seconds (epoch_seconds),
    .zone_offset   (zone_offset),
    .out_valid     (day_valid),
    .out_day       (day)
  );

  ecal_tod u_tod (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (day_valid),
    .tod       (day.tod),
    .out_valid (tod_valid),
    .out_tod   (tod_res)
  );

  ecal_date u_date (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (day_valid),
    .z         (day.z),
    .out_valid (date_valid),
    .out_date  (date_res)
  );

  assign done             = date_valid;
  assign second           = tod_res.second;
  assign minute           = tod_res.minute;
  assign hour             = tod_res.hour;
  assign day_of_month     = date_res.day_of_month;
  assign month_index      = date_res.month_index;
  assign years_since_1900 = date_res.years_since_1900;
  assign weekday          = date_res.weekday;
  assign day_of_year      = date_res.day_of_year;

  // time-of-day and date paths must stay in lockstep
  a_paths_aligned: assert property (@(posedge clk) disable iff (rst)
    tod_valid == date_valid)
    else $error("time and date paths out of step");

  a_fixed_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("result strobe missing after accepted word");

  a_ranges: assert property (@(posedge clk) disable iff (rst)
    done |-> (second < 6'd60 && minute < 6'd60 && hour < 5'd24 && weekday < 3'd7
              && month_index < 4'd12 && day_of_month != 5'd0 && day_of_year < 9'd366))
    else $error("result field out of range");

endmodule
`default_nettype wire

// ===== design/ecal_split.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ecal_split import ecal_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire logic [EPOCH_W-1:0]  epoch_seconds,
  input  wire logic [OFFSET_W-1:0] zone_offset,
  output logic                     out_valid,
  output ecal_day_t                out_day
);

  logic             s1_valid, s2_valid;
  logic [SUM_W-1:0] s1_u;
  logic [52:0]      s2_prod;
  logic [V_W-1:0]   s2_v;
  logic [6:0]       s2_low;

  logic [SUM_W:0]    sum_next;
  logic [DAYS_W-1:0] q;
  logic [V_W-1:0]    q675;
  logic [V_W-1:0]    r_full;

  // biased sum is never negative, so floor division becomes plain unsigned division
  assign sum_next = {{2{epoch_seconds[EPOCH_W-1]}}, epoch_seconds}
                  + {{(SUM_W + 1 - OFFSET_W){zone_offset[OFFSET_W-1]}}, zone_offset}
                  + DAY_BIAS;

  // 86400 = 128 * 675
  assign q      = s2_prod[36 + DAYS_W - 1:36];
  assign q675   = V_W'(q) * 26'd675;
  assign r_full = s2_v - q675;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid  <= in_valid;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_u        <= sum_next[SUM_W-1:0];
    s2_v        <= s1_u[SUM_W-1:7];
    s2_low      <= s1_u[6:0];
    s2_prod     <= s1_u[SUM_W-1:7] * RECIP_675;
    out_day.z   <= {4'b0, q} + Z_BASE;
    out_day.tod <= {r_full[9:0], s2_low};
  end

endmodule
`default_nettype wire

// ===== design/ecal_tod.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ecal_tod import ecal_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire logic [TOD_W-1:0] tod,
  output logic                  out_valid,
  output ecal_tod_t             out_tod
);

  logic [2:0]       t_valid;
  logic [34:0]      t1_ph;
  logic [TOD_W-1:0] t1_tod;
  logic [4:0]       t2_hour;
  logic [11:0]      t2_rem;
  logic [24:0]      t3_pmin;
  logic [4:0]       t3_hour;
  logic [11:0]      t3_rem;

  logic [TOD_PAD-1:0] pad_valid;
  ecal_tod_t          pad_data [TOD_PAD];

  logic [4:0]       hour_c;
  logic [TOD_W-1:0] h3600;
  logic [TOD_W-1:0] rem_full;
  logic [5:0]       min_c;
  logic [11:0]      m60;
  logic [11:0]      sec_full;

  assign hour_c   = t1_ph[33:29];
  assign h3600    = TOD_W'(hour_c) * 17'd3600;
  assign rem_full = t1_tod - h3600;
  assign min_c    = t3_pmin[23:18];
  assign m60      = 12'(min_c) * 12'd60;
  assign sec_full = t3_rem - m60;

  always_ff @(posedge clk) begin
    if (rst) begin
      t_valid   <= '0;
      pad_valid <= '0;
    end else begin
      t_valid   <= {t_valid[1:0], in_valid};
      pad_valid <= {pad_valid[TOD_PAD-2:0], t_valid[2]};
    end
  end

  always_ff @(posedge clk) begin
    t1_ph   <= tod * RECIP_3600;
    t1_tod  <= tod;
    t2_hour <= hour_c;
    t2_rem  <= rem_full[11:0];
    t3_pmin <= t2_rem * RECIP_60;
    t3_hour <= t2_hour;
    t3_rem  <= t2_rem;
    pad_data[0].second <= sec_full[5:0];
    pad_data[0].minute <= min_c;
    pad_data[0].hour   <= t3_hour;
    for (int i = 1; i < TOD_PAD; i++) begin
      pad_data[i] <= pad_data[i-1];
    end
  end

  // delay line keeps this path aligned with the date path
  assign out_valid = pad_valid[TOD_PAD-1];
  assign out_tod   = pad_data[TOD_PAD-1];

endmodule
`default_nettype wire

// ===== design/ecal_date.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ecal_date import ecal_pkg::*; (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  input  wire logic [Z_W-1:0] z,
  output logic                out_valid,
  output ecal_date_t          out_date
);

  logic [DATE_STAGES-1:0] vld;

  // stage 1
  logic [DOE_W-1:0] d1_doe;
  logic [ERA_W-1:0] d1_era;
  logic [Z_W-1:0]   d1_xw;
  logic [40:0]      d1_pw;
  // stage 2
  logic [DOE_W-1:0] d2_n, d2_doe;
  logic [ERA_W-1:0] d2_era;
  logic [2:0]       d2_wday;
  // stage 3
  logic [36:0]      d3_py;
  logic [DOE_W-1:0] d3_doe;
  logic [ERA_W-1:0] d3_era;
  logic [2:0]       d3_wday;
  // stage 4
  logic [YOE_W-1:0] d4_yoe;
  logic [DOY_W-1:0] d4_doy;
  logic [ERA_W-1:0] d4_era;
  logic [2:0]       d4_wday;
  // stage 5
  logic [22:0]      d5_pmp;
  logic [DOY_W-1:0] d5_doy;
  logic [YOE_W-1:0] d5_yoe;
  logic [ERA_W-1:0] d5_era;
  logic [2:0]       d5_wday;
  // stage 6
  logic [10:0]      d6_t153;
  logic [3:0]       d6_mon;
  logic [7:0]       d6_ys;
  logic             d6_leap;
  logic [DOY_W-1:0] d6_doy;
  logic [2:0]       d6_wday;
  // stage 7
  logic [22:0]      d7_pd5;
  logic [3:0]       d7_mon;
  logic [7:0]       d7_ys;
  logic             d7_leap;
  logic [DOY_W-1:0] d7_doy;
  logic [2:0]       d7_wday;

  logic [ERA_W-1:0] era_c;
  logic [Z_W-1:0]   era_base;
  logic [Z_W-1:0]   xw_c;
  logic [36:0]      pa, pb;
  logic             last_day;
  logic [DOE_W-1:0] n_c;
  logic [17:0]      q7;
  logic [Z_W-1:0]   q7x7, wday_full;
  logic [YOE_W-1:0] yoe_c;
  logic [18:0]      p100;
  logic [DOE_W-1:0] yr_days, doy_full;
  logic [10:0]      x5;
  logic [3:0]       mp, mon_c;
  logic [YOE_W-1:0] y4;
  logic [YEAR_W-1:0] year_c, ys_full;
  logic             leap_c;
  logic [DOY_W-1:0] dm, mday_full, yday_c;

  // era search: a few independent compares
  always_comb begin
    era_c = '0;
    for (int k = 1; k < (1 << ERA_W); k++) begin
      if (z >= Z_W'(k) * ERA_DAYS) begin
        era_c = ERA_W'(k);
      end
    end
  end
  assign era_base = Z_W'(era_c) * ERA_DAYS;
  assign xw_c     = z + 20'd3;

  // year of era: doe - doe/1460 + doe/36524 - doe/146096, all over 365
  assign pa        = d1_doe * RECIP_1460;
  assign pb        = d1_doe * RECIP_36524;
  assign last_day  = (d1_doe == LAST_DOE);
  assign n_c       = d1_doe - DOE_W'(pa[36:29]) + DOE_W'(pb[36:34]) - DOE_W'(last_day);
  assign q7        = d1_pw[40:23];
  assign q7x7      = Z_W'(q7) * 20'd7;
  assign wday_full = d1_xw - q7x7;

  assign yoe_c    = d3_py[35:27];
  assign p100     = 19'(yoe_c) * 19'(RECIP_100);
  assign yr_days  = DOE_W'(yoe_c) * 18'd365 + DOE_W'(yoe_c[YOE_W-1:2])
                  - DOE_W'(p100[18:16]);
  assign doy_full = d3_doe - yr_days;

  assign x5 = 11'(d4_doy) * 11'd5 + 11'd2;

  // March-based month back to January-based
  assign mp     = d5_pmp[22:19];
  assign mon_c  = (mp < 4'd10) ? mp + 4'd2 : mp - 4'd10;
  assign y4     = d5_yoe + YOE_W'(mon_c < 4'd2);
  assign year_c = YEAR_W'(d5_era) * 12'd400 + YEAR_W'(y4);
  assign ys_full = year_c - 12'd1900;
  // era*400 drops out of the 4/100/400 test
  assign leap_c = (y4[1:0] == 2'd0) && !(y4 == 9'd100 || y4 == 9'd200 || y4 == 9'd300);

  assign dm        = d7_pd5[22:14];
  assign mday_full = d7_doy - dm + 9'd1;
  assign yday_c    = days_before_month(d7_mon) + d7_doy - dm
                   + DOY_W'(d7_mon >= 4'd2 && d7_leap);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[DATE_STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    d1_doe  <= DOE_W'(z - era_base);
    d1_era  <= era_c;
    d1_xw   <= xw_c;
    d1_pw   <= xw_c * RECIP_7;

    d2_n    <= n_c;
    d2_doe  <= d1_doe;
    d2_era  <= d1_era;
    d2_wday <= wday_full[2:0];

    d3_py   <= d2_n * RECIP_365;
    d3_doe  <= d2_doe;
    d3_era  <= d2_era;
    d3_wday <= d2_wday;

    d4_yoe  <= yoe_c;
    d4_doy  <= doy_full[DOY_W-1:0];
    d4_era  <= d3_era;
    d4_wday <= d3_wday;

    d5_pmp  <= x5 * RECIP_153;
    d5_doy  <= d4_doy;
    d5_yoe  <= d4_yoe;
    d5_era  <= d4_era;
    d5_wday <= d4_wday;

    d6_t153 <= 11'(mp) * 11'd153 + 11'd2;
    d6_mon  <= mon_c;
    d6_ys   <= ys_full[7:0];
    d6_leap <= leap_c;
    d6_doy  <= d5_doy;
    d6_wday <= d5_wday;

    d7_pd5  <= d6_t153 * RECIP_5;
    d7_mon  <= d6_mon;
    d7_ys   <= d6_ys;
    d7_leap <= d6_leap;
    d7_doy  <= d6_doy;
    d7_wday <= d6_wday;

    out_date.day_of_month     <= mday_full[4:0];
    out_date.month_index      <= d7_mon;
    out_date.years_since_1900 <= d7_ys;
    out_date.weekday          <= d7_wday;
    out_date.day_of_year      <= yday_c;
  end

  assign out_valid = vld[DATE_STAGES-1];

endmodule
`default_nettype wire

// ===== bench/epoch_seconds_to_calendar_core_tb.sv =====
`timescale 1ns / 1ps
module epoch_seconds_to_calendar_core_tb;
  import ecal_pkg::*;

  typedef enum logic [1:0] {STEP_WORD, STEP_DRAIN, STEP_OFFSET} step_kind_t;

  typedef struct {
    step_kind_t         kind;
    logic [EPOCH_W-1:0] value;
    bit                 gappy;
  } step_t;

  typedef struct packed {
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [4:0] day_of_month;
    logic [3:0] month_index;
    logic [7:0] years_since_1900;
    logic [2:0] weekday;
    logic [8:0] day_of_year;
  } calendar_t;

  typedef struct {
    calendar_t           cal;
    logic [EPOCH_W-1:0]  epoch;
    logic [OFFSET_W-1:0] offset;
  } due_t;

  localparam int MONTH_START [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic [EPOCH_W-1:0]  epoch_seconds = '0;
  logic                cfg_we = 1'b0;
  logic [OFFSET_W-1:0] zone_offset_seconds = '0;

  wire       busy;
  wire       done;
  wire [5:0] second;
  wire [5:0] minute;
  wire [4:0] hour;
  wire [4:0] day_of_month;
  wire [3:0] month_index;
  wire [7:0] years_since_1900;
  wire [2:0] weekday;
  wire [8:0] day_of_year;

  step_t               pending_words[$];
  due_t                calendar_due[$];
  logic [OFFSET_W-1:0] offset_now = '0;
  int                  settle = 0;
  int                  words_sent = 0;
  int                  offsets_set = 0;
  int                  dates_seen = 0;
  int                  mismatches = 0;

  epoch_seconds_to_calendar_core u_dut (
    .clk                 (clk),
    .rst                 (rst),
    .start               (start),
    .busy                (busy),
    .epoch_seconds       (epoch_seconds),
    .cfg_we              (cfg_we),
    .zone_offset_seconds (zone_offset_seconds),
    .done                (done),
    .second              (second),
    .minute              (minute),
    .hour                (hour),
    .day_of_month        (day_of_month),
    .month_index         (month_index),
    .years_since_1900    (years_since_1900),
    .weekday             (weekday),
    .day_of_year         (day_of_year)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit leap_year(input longint y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic calendar_t calendar_of(input logic [EPOCH_W-1:0] ep,
                                            input logic [OFFSET_W-1:0] off);
    longint    total, day, secs, shifted, era, doe, yoe, doy, mp, mday, mon, year, yday, wd;
    calendar_t c;
    total = longint'($signed(ep)) + longint'($signed(off));
    day   = total / 86400;
    secs  = total % 86400;
    // floor split: instants before midnight belong to the previous day
    if (secs < 0) begin
      secs += 86400;
      day  -= 1;
    end
    // years counted from 0000-03-01 so the leap day is the last of each year
    shifted = day + 719468;
    era     = shifted / 146097;
    doe     = shifted - era * 146097;
    yoe     = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy     = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp      = (5 * doy + 2) / 153;
    mday    = doy - (153 * mp + 2) / 5 + 1;
    mon     = (mp < 10) ? mp + 2 : mp - 10;
    year    = era * 400 + yoe + ((mon < 2) ? 1 : 0);
    yday    = MONTH_START[mon] + mday - 1;
    if (mon >= 2 && leap_year(year)) yday += 1;
    // 1970-01-01 was a Thursday
    wd = (day + 4) % 7;
    if (wd < 0) wd += 7;
    c.second           = 6'(secs % 60);
    c.minute           = 6'((secs / 60) % 60);
    c.hour             = 5'(secs / 3600);
    c.day_of_month     = 5'(mday);
    c.month_index      = 4'(mon);
    c.years_since_1900 = 8'(year - 1900);
    c.weekday          = 3'(wd);
    c.day_of_year      = 9'(yday);
    return c;
  endfunction

  function automatic string fmt_cal(input calendar_t c);
    return $sformatf("y%0d m%0d d%0d %0d:%0d:%0d wd%0d yd%0d", c.years_since_1900,
                     c.month_index, c.day_of_month, c.hour, c.minute, c.second,
                     c.weekday, c.day_of_year);
  endfunction

  task automatic flag_error(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("ERROR @%0t: %s", $time, msg);
  endtask

  // driver: one word at a time from the pending queue
  always @(posedge clk) begin : drive
    bit                  nx_start, nx_we, idle;
    logic [EPOCH_W-1:0]  nx_epoch;
    logic [OFFSET_W-1:0] nx_off;
    step_t               head;
    nx_start = start;
    nx_we    = 1'b0;
    nx_epoch = epoch_seconds;
    nx_off   = zone_offset_seconds;
    if (rst) begin
      nx_start   = 1'b0;
      offset_now = '0;
    end else begin
      if (cfg_we) offset_now = zone_offset_seconds;
      if (start && !busy) begin
        calendar_due.push_back('{calendar_of(epoch_seconds, offset_now), epoch_seconds,
                                 offset_now});
        words_sent++;
        nx_start = 1'b0;
      end
      if (!nx_start) begin
        if (settle != 0) begin
          settle--;
        end else if (pending_words.size() != 0) begin
          head = pending_words[0];
          case (head.kind)
            STEP_WORD: begin
              idle = head.gappy && ($urandom_range(0, 99) < 15);
              if (!idle) begin
                void'(pending_words.pop_front());
                nx_start = 1'b1;
                nx_epoch = head.value;
              end
            end
            STEP_DRAIN: begin
              if (calendar_due.size() == 0) begin
                void'(pending_words.pop_front());
                settle = LATENCY + 2;
              end
            end
            STEP_OFFSET: begin
              void'(pending_words.pop_front());
              nx_we  = 1'b1;
              nx_off = head.value[OFFSET_W-1:0];
              offsets_set++;
            end
            default: void'(pending_words.pop_front());
          endcase
        end
      end
    end
    start               <= nx_start;
    cfg_we              <= nx_we;
    epoch_seconds       <= nx_epoch;
    zone_offset_seconds <= nx_off;
  end

  // monitor: done is a one-cycle strobe, capture on every edge it is high
  always @(posedge clk) begin : watch
    due_t      want;
    calendar_t got;
    if (!rst && done) begin
      got = '{second, minute, hour, day_of_month, month_index, years_since_1900, weekday,
              day_of_year};
      dates_seen++;
      if (calendar_due.size() == 0) begin
        flag_error($sformatf("unexpected result %s", fmt_cal(got)));
      end else begin
        want = calendar_due.pop_front();
        if (got !== want.cal)
          flag_error($sformatf("epoch %0d offset %0d: exp %s got %s", $signed(want.epoch),
                               $signed(want.offset), fmt_cal(want.cal), fmt_cal(got)));
      end
    end
  end

  initial begin : stimulus
    logic [EPOCH_W-1:0] corner_words [19] = '{
      32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
      32'd86399, 32'd86400, -32'sd86400, -32'sd86401,
      32'd68169600, 32'd68256000, 32'd946684799, 32'd951782400,
      32'd951868800, 32'd978307199, -32'sd31536001, -32'sd31536000,
      32'd1000000000, 32'hAAAA_AAAA, 32'h5555_5555
    };
    int                 zone_list [8] = '{86399, -86399, 131071, -131072, -1, 19800, 0, 0};
    int                 day;
    int                 off;
    logic [EPOCH_W-1:0] w;
    bit                 gappy;
    foreach (corner_words[i]) pending_words.push_back('{STEP_WORD, corner_words[i], 1'b1});
    for (int p = 0; p < 8; p++) begin
      off = zone_list[p];
      if (p == 6) off = int'($urandom_range(0, 262143)) - 131072;
      if (p == 7) off = int'($urandom_range(0, 172798)) - 86399;
      pending_words.push_back('{STEP_DRAIN, '0, 1'b0});
      pending_words.push_back('{STEP_OFFSET, 32'(off), 1'b0});
      gappy = (p != 4);
      pending_words.push_back('{STEP_WORD, 32'h8000_0000, gappy});
      pending_words.push_back('{STEP_WORD, 32'h7FFF_FFFF, gappy});
      for (int k = 0; k < 90; k++) begin
        // sender stops mid-phase until the pipe is empty
        if (p == 1 && k == 40) pending_words.push_back('{STEP_DRAIN, '0, 1'b0});
        day = int'($urandom_range(0, 49709)) - 24855;
        case ($urandom_range(0, 3))
          0, 1: w = $urandom();
          2: w = 32'(longint'(day) * 86400 + longint'($urandom_range(0, 4)) - 2);
          default: w = 32'(longint'(day) * 86400 + 3600 * $urandom_range(0, 23) +
                           60 * $urandom_range(0, 59) + ($urandom_range(0, 1) ? 59 : 0));
        endcase
        pending_words.push_back('{STEP_WORD, w, gappy});
      end
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    while (pending_words.size() != 0 || start || calendar_due.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    $display("%0d words converted across %0d offset writes, %0d results checked",
             words_sent, offsets_set, dates_seen);
    $display("covered both ends of the 32-bit range, leap days and offsets past one day");
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d errors", mismatches);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("timeout with %0d results outstanding", calendar_due.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
